@@ sv/mtpo_pkg.sv @@
`default_nettype none

package mtpo_pkg;

  // Default sizes for the top level parameters.
  localparam int PHASE_BITS_DEF  = 24;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Quarter-wave sine entries are Q30 and reach 2^30 at the peak.
  localparam int SINE_W = 31;

  // Sum width for the Q46 mix, with headroom for the largest timbre.
  localparam int SUM_W = 50;

  // Noise generator seed after reset.
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  // Q16 multiplier for the 2.07x partial.
  localparam logic [17:0] RATIO_207 = 18'd135660;

  // Waveform codes held in the configuration register.
  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SAW      = 3'd2,
    WAVE_NOISE    = 3'd3,
    WAVE_RECORDER = 3'd4,
    WAVE_SPROUT   = 3'd5,
    WAVE_FERN     = 3'd6
  } wave_t;

  // Q16 partial weights for the five sine slots and the breath noise term.
  typedef struct packed {
    logic [16:0] w0;
    logic [16:0] w1;
    logic [16:0] w2;
    logic [16:0] w3;
    logic [16:0] w4;
    logic [12:0] wn;
  } weights_t;

  // Slot 3 carries the 4x partial, or the 5x partial for sprout.
  // Slot 4 carries the 6x partial for sprout and the 2.07x partial for fern.
  function automatic weights_t mix_weights(logic [2:0] wave);
    weights_t r;
    r = '0;
    unique case (wave)
      WAVE_SINE: begin
        r.w0 = 17'd65536;
      end
      WAVE_RECORDER: begin
        r.w0 = 17'd65536;
        r.w1 = 17'd9175;
        r.w2 = 17'd3604;
        r.w3 = 17'd1573;
        r.wn = 13'd5767;
      end
      WAVE_SPROUT: begin
        r.w0 = 17'd65536;
        r.w1 = 17'd7209;
        r.w2 = 17'd2359;
        r.w3 = 17'd4063;
        r.w4 = 17'd1442;
        r.wn = 13'd6554;
      end
      WAVE_FERN: begin
        r.w0 = 17'd65536;
        r.w1 = 17'd13107;
        r.w2 = 17'd5767;
        r.w3 = 17'd2228;
        r.w4 = 17'd3801;
        r.wn = 13'd4194;
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  // Sine of t (Q30 fraction of a quarter turn) by a truncating Horner series.
  // Only evaluated on constants while the table is built.
  function automatic logic [SINE_W-1:0] sine_poly(logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] acc;
    t2  = (t * t) >> 30;
    acc = 64'd5026995 - ((t2 * 64'd172272) >> 30);
    acc = 64'd85569306 - ((t2 * acc) >> 30);
    acc = 64'd693598668 - ((t2 * acc) >> 30);
    acc = 64'd1686629713 - ((t2 * acc) >> 30);
    acc = (t * acc) >> 30;
    if (acc > (64'd1 << 30)) begin
      acc = 64'd1 << 30;
    end
    return acc[SINE_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/multi_timbre_phase_oscillator.sv @@
`default_nettype none

// A sample leaves on m_axis once its transferred tick has passed through every pipeline stage.
// Throughput: one tick per cycle; each stage of the nine-stage pipeline holds
// one item and stalls only when the stage after it is full and not moving.
// Reset (rst, synchronous): phase accumulator cleared, noise LFSR seeded with
// 0xACE1, waveform set to sine, pipeline emptied.
module multi_timbre_phase_oscillator import mtpo_pkg::*; #(
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Waveform register write.
  input  wire logic        cfg_wen,
  input  wire logic [2:0]  cfg_wdata,
  // Tick in. tdata: phase_step [23:0], breath [32:24], zeros above.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,
  // Sample out. tdata: sample [SAMPLE_BITS-1:0], zeros above.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int NSTG  = 9;
  localparam int NSLOT = 5;
  localparam int AW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IW    = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int PW    = PHASE_BITS + IW;
  localparam int SH46  = 46 - PHASE_BITS;
  localparam int RSH   = 47 - SAMPLE_BITS;

  localparam logic [IW-1:0] QD1 = IW'(SINE_TABLE_DEPTH);
  localparam logic [IW-1:0] QD2 = IW'(2 * SINE_TABLE_DEPTH);
  localparam logic [IW-1:0] QD3 = IW'(3 * SINE_TABLE_DEPTH);

  localparam logic signed [SUM_W-1:0] ONE46 = SUM_W'(64'd1 << 46);
  localparam logic signed [47:0]      LIM48 = 48'(64'd1 << 46);

  // ---------------------------------------------------------------------
  // Handshake: each stage moves when it is empty or the next one moves.
  // ---------------------------------------------------------------------
  logic [NSTG:1] vld;
  logic [NSTG:1] adv;
  logic          accept;

  always_comb begin
    adv[NSTG] = !vld[NSTG] || m_axis_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[1];
  assign m_axis_tvalid = vld[NSTG];
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Configuration, phase accumulator and noise generator.
  // ---------------------------------------------------------------------
  logic [2:0]            waveform;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] step_s;
  logic [15:0]           lfsr;
  logic [15:0]           lfsr_next;
  logic [8:0]            breath_in;

  if (PHASE_BITS >= 24) begin : g_step_up
    assign step_s = PHASE_BITS'(s_axis_tdata[23:0]) << (PHASE_BITS - 24);
  end else begin : g_step_down
    assign step_s = s_axis_tdata[23:24-PHASE_BITS];
  end

  assign breath_in = s_axis_tdata[32:24];
  assign lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform  <= WAVE_SINE;
      phase_acc <= '0;
      lfsr      <= LFSR_SEED;
    end else begin
      if (cfg_wen) begin
        waveform <= cfg_wdata;
      end
      if (accept) begin
        phase_acc <= phase_acc + step_s;
        lfsr      <= lfsr_next;
      end
    end
  end

  // Stage 1: phase before the advance, fresh noise value, clamped breath.
  logic [PHASE_BITS-1:0] ph1;
  logic signed [15:0]    noise1;
  logic [8:0]            breath1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ph1     <= phase_acc;
      noise1  <= {~lfsr_next[15], lfsr_next[14:0]};
      breath1 <= (breath_in > 9'd256) ? 9'd256 : breath_in;
    end
  end

  // Stage 2: phase of each partial, direct waveform value, breath times noise.
  logic [PHASE_BITS-1:0]    phs_c [NSLOT];
  logic [PHASE_BITS+17:0]   fern_prod;
  logic signed [SUM_W-1:0]  p46;
  logic signed [SUM_W-1:0]  dir_c;
  logic [PHASE_BITS-1:0]    phs2 [NSLOT];
  logic signed [SUM_W-1:0]  dir2;
  logic signed [25:0]       bn2;

  assign fern_prod = (PHASE_BITS+18)'(ph1) * (PHASE_BITS+18)'(RATIO_207);
  assign p46       = SUM_W'(ph1) << SH46;

  always_comb begin
    phs_c[0] = ph1;
    phs_c[1] = PHASE_BITS'(ph1 << 1);
    phs_c[2] = PHASE_BITS'(ph1 * 3);
    phs_c[3] = (waveform == WAVE_SPROUT) ? PHASE_BITS'(ph1 * 5) : PHASE_BITS'(ph1 << 2);
    phs_c[4] = (waveform == WAVE_FERN) ? fern_prod[PHASE_BITS+15:16]
                                       : PHASE_BITS'(ph1 * 6);
  end

  // Triangle, saw and raw noise bypass the sine table.
  always_comb begin
    unique case (waveform)
      WAVE_TRIANGLE: begin
        if (ph1[PHASE_BITS-1]) begin
          dir_c = ONE46 + ONE46 + ONE46 - (p46 <<< 2);
        end else begin
          dir_c = (p46 <<< 2) - ONE46;
        end
      end
      WAVE_SAW: begin
        dir_c = (p46 <<< 1) - ONE46;
      end
      WAVE_NOISE: begin
        dir_c = SUM_W'(noise1) <<< 31;
      end
      default: begin
        dir_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      phs2 <= phs_c;
      dir2 <= dir_c;
      bn2  <= $signed({1'b0, breath1}) * noise1;
    end
  end

  // Stage 3: table address and sign per partial, weighted noise term.
  weights_t              wts;
  logic [PW-1:0]         idx_prod [NSLOT];
  logic [IW-1:0]         idx      [NSLOT];
  logic [IW-1:0]         rem      [NSLOT];
  logic [1:0]            quad     [NSLOT];
  logic [AW-1:0]         addr_c   [NSLOT];
  logic [AW-1:0]         addr3    [NSLOT];
  logic [NSLOT-1:0]      neg3;
  logic signed [SUM_W-1:0] dir3;
  logic signed [39:0]    nt3;

  assign wts = mix_weights(waveform);

  // The full turn spans 4*DEPTH steps; the quadrant picks entry and sign.
  always_comb begin
    for (int g = 0; g < NSLOT; g++) begin
      idx_prod[g] = PW'(phs2[g]) * PW'(4 * SINE_TABLE_DEPTH);
      idx[g]      = idx_prod[g][PW-1:PHASE_BITS];
      priority if (idx[g] >= QD3) begin
        quad[g] = 2'd3;
        rem[g]  = idx[g] - QD3;
      end else if (idx[g] >= QD2) begin
        quad[g] = 2'd2;
        rem[g]  = idx[g] - QD2;
      end else if (idx[g] >= QD1) begin
        quad[g] = 2'd1;
        rem[g]  = idx[g] - QD1;
      end else begin
        quad[g] = 2'd0;
        rem[g]  = idx[g];
      end
      addr_c[g] = quad[g][0] ? AW'(QD1 - rem[g]) : AW'(rem[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      addr3 <= addr_c;
      for (int g = 0; g < NSLOT; g++) begin
        neg3[g] <= quad[g][1];
      end
      dir3 <= dir2;
      nt3  <= bn2 * $signed({1'b0, wts.wn});
    end
  end

  // Stage 4: one table read per partial.
  logic [SINE_W-1:0]       data4 [NSLOT];
  logic [NSLOT-1:0]        neg4;
  logic signed [SUM_W-1:0] dir4;
  logic signed [39:0]      nt4;

  for (genvar g = 0; g < NSLOT; g++) begin : g_rom
    mtpo_sine_rom #(
      .DEPTH (SINE_TABLE_DEPTH),
      .AW    (AW)
    ) u_rom (
      .clk  (clk),
      .en   (adv[4]),
      .addr (addr3[g]),
      .data (data4[g])
    );
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      neg4 <= neg3;
      dir4 <= dir3;
      nt4  <= nt3;
    end
  end

  // Stage 5: weight each partial into Q46.
  logic [16:0]             wsl [NSLOT];
  logic [47:0]             mag [NSLOT];
  logic signed [SUM_W-1:0] prod5 [NSLOT];
  logic signed [SUM_W-1:0] dir5;
  logic signed [SUM_W-1:0] nt5;

  assign wsl[0] = wts.w0;
  assign wsl[1] = wts.w1;
  assign wsl[2] = wts.w2;
  assign wsl[3] = wts.w3;
  assign wsl[4] = wts.w4;

  always_comb begin
    for (int g = 0; g < NSLOT; g++) begin
      mag[g] = 48'(data4[g]) * 48'(wsl[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int g = 0; g < NSLOT; g++) begin
        prod5[g] <= neg4[g] ? -SUM_W'(mag[g]) : SUM_W'(mag[g]);
      end
      dir5 <= dir4;
      nt5  <= SUM_W'(nt4) <<< 7;
    end
  end

  // Stages 6 and 7: adder tree over the seven terms.
  logic signed [SUM_W-1:0] a6, b6, c6, d6;
  logic signed [SUM_W-1:0] e7, f7;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      a6 <= prod5[0] + prod5[1];
      b6 <= prod5[2] + prod5[3];
      c6 <= prod5[4] + nt5;
      d6 <= dir5;
    end
    if (adv[7]) begin
      e7 <= a6 + b6;
      f7 <= c6 + d6;
    end
  end

  // Stage 8: final sum, saturated to plus or minus one.
  logic signed [SUM_W-1:0] mix;
  logic signed [47:0]      clamp8;

  assign mix = e7 + f7;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      if (mix > ONE46) begin
        clamp8 <= LIM48;
      end else if (mix < -ONE46) begin
        clamp8 <= -LIM48;
      end else begin
        clamp8 <= 48'(mix);
      end
    end
  end

  // Stage 9: round half up to the sample code; plus one maps to the top code.
  logic [47:0]          biased;
  logic [SAMPLE_BITS:0] code;
  logic [SAMPLE_BITS-1:0] sample9;

  assign biased = $unsigned(clamp8) + (48'd1 << 46) + (48'd1 << (RSH - 1));
  assign code   = biased[47:RSH];

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      if (code[SAMPLE_BITS]) begin
        sample9 <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
        sample9 <= {~code[SAMPLE_BITS-1], code[SAMPLE_BITS-2:0]};
      end
    end
  end

  assign m_axis_tdata = OUT_W'(sample9);

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------

  // The accumulator moves by exactly the scaled step on each transfer.
  a_phase_advance: assert property (@(posedge clk) disable iff (rst)
    accept |=> phase_acc == $past(phase_acc + step_s))
    else $error("phase accumulator did not advance by the step");

  // Phase and noise state only change on a transfer.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase_acc) && $stable(lfsr))
    else $error("oscillator state changed without a transfer");

  // The LFSR never falls into the all-zero lockup state.
  a_lfsr_live: assert property (@(posedge clk) disable iff (rst)
    lfsr != 16'd0)
    else $error("noise LFSR reached zero");

  // The saturated mix stays within plus or minus one.
  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    vld[8] |-> (clamp8 <= LIM48) && (clamp8 >= -LIM48))
    else $error("saturated mix out of range");

endmodule

`default_nettype wire

@@ sv/mtpo_sine_rom.sv @@
`default_nettype none

module mtpo_sine_rom import mtpo_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(TABLE_DEPTH_DEF + 1)
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [AW-1:0]     addr,
  output logic      [SINE_W-1:0] data
);

  // Quarter-wave table with DEPTH+1 entries, built from constants.
  logic [SINE_W-1:0] rom [DEPTH+1];

  for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
    localparam logic [63:0] T = (64'(k) << 30) / DEPTH;
    assign rom[k] = sine_poly(T);
  end

  // Registered read, held while the pipeline stalls.
  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end

endmodule

`default_nettype wire
